[rtl/ptlru_pkg.sv]
// Shared types and constants for the partitioned timestamp LRU engine.
package ptlru_pkg;

  localparam int OPCODE_W  = 2;
  localparam int SET_IDX_W = 6;
  localparam int WAY_IDX_W = 4;
  localparam int RSV_W     = 5;

  localparam logic [RSV_W-1:0] RSV_RST = 5'd8;

  localparam logic [OPCODE_W-1:0] OP_VICTIM = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FILL   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ACCESS = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

[rtl/ptlru_if.sv]
// Request and result channel interfaces of the LRU engine.
interface ptlru_in_if
  import ptlru_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [SET_IDX_W-1:0] set_index;
  logic [WAY_IDX_W-1:0] way_index;
  logic                 is_hit;
  logic                 is_write;

  modport source (output valid, opcode, set_index, way_index, is_hit, is_write,
                  input ready);
  modport sink   (input valid, opcode, set_index, way_index, is_hit, is_write,
                  output ready);
endinterface

interface ptlru_out_if
  import ptlru_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [WAY_IDX_W-1:0] victim_way;
  logic                 victim_valid;

  modport source (output valid, victim_way, victim_valid, input ready);
  modport sink   (input valid, victim_way, victim_valid, output ready);
endinterface

[rtl/ptlru_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ptlru_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/partitioned_timestamp_lru_top.sv]
// Top level of the partitioned timestamp LRU engine: sequencer, comparator and stamp RAM.
// Victim request: the stamp RAM is read one way per cycle, from reserved_ways up to WAYS - 1,
// feeding a single shared compare unit.
// Fill or stamping access: one RAM write in ST_WRITE, then ST_DONE; any other non-victim item goes straight to ST_DONE.
// The result sits in an output register; the next item is taken while it waits.
// After reset a clearing pass writes zero to all SETS * 2**WAY_W stamp entries
// (1024 by default) before the first item is taken.
module partitioned_timestamp_lru_top
  import ptlru_pkg::*;
#(
  parameter int SETS       = 64,
  parameter int WAYS       = 16,
  parameter int STAMP_BITS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  ptlru_in_if.sink         in_ch,
  ptlru_out_if.source      out_ch,
  input  logic             cfg_we,
  input  logic [RSV_W-1:0] cfg_data
);

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ITER_W = WAY_W + 1;
  localparam int ADDR_W = SET_W + WAY_W;
  localparam int DEPTH  = SETS * (2 ** WAY_W);

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [ITER_W-1:0] WAYS_I   = ITER_W'(WAYS);

  state_t                 state_r, state_nxt;
  logic [RSV_W-1:0]       rsv_r;
  logic [STAMP_BITS-1:0]  use_cnt_r, use_cnt_nxt;
  logic [ADDR_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [SET_W-1:0]       set_r, set_nxt;
  logic [WAY_W-1:0]       way_r, way_nxt;
  logic [ITER_W-1:0]      iss_way_r, iss_way_nxt;
  logic [WAY_W-1:0]       cmp_way_r, cmp_way_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic                   first_r, first_nxt;
  logic [WAY_W-1:0]       best_way_r, best_way_nxt;
  logic [STAMP_BITS-1:0]  best_stamp_r, best_stamp_nxt;
  logic                   res_vld_r, res_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [WAY_IDX_W-1:0]   out_way_r, out_way_nxt;
  logic                   out_vv_r, out_vv_nxt;

  logic                   ram_wr_en;
  logic [ADDR_W-1:0]      ram_wr_addr;
  logic [STAMP_BITS-1:0]  ram_wr_data;
  logic                   ram_rd_en;
  logic [ADDR_W-1:0]      ram_rd_addr;
  logic [STAMP_BITS-1:0]  ram_rd_data;

  logic in_fire;
  logic set_ok, way_ok, rsv_ok;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign set_ok = 32'(in_ch.set_index) < 32'(SETS);
  assign way_ok = 32'(in_ch.way_index) < 32'(WAYS);
  assign rsv_ok = 32'(rsv_r) < 32'(WAYS);

  ptlru_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (DEPTH)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      rsv_r       <= RSV_RST;
      use_cnt_r   <= '0;
      clr_cnt_r   <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      use_cnt_r   <= use_cnt_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        rsv_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    set_r        <= set_nxt;
    way_r        <= way_nxt;
    iss_way_r    <= iss_way_nxt;
    cmp_way_r    <= cmp_way_nxt;
    first_r      <= first_nxt;
    best_way_r   <= best_way_nxt;
    best_stamp_r <= best_stamp_nxt;
    res_vld_r    <= res_vld_nxt;
    out_way_r    <= out_way_nxt;
    out_vv_r     <= out_vv_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    use_cnt_nxt    = use_cnt_r;
    clr_cnt_nxt    = clr_cnt_r;
    set_nxt        = set_r;
    way_nxt        = way_r;
    iss_way_nxt    = iss_way_r;
    cmp_way_nxt    = cmp_way_r;
    cmp_vld_nxt    = cmp_vld_r;
    first_nxt      = first_r;
    best_way_nxt   = best_way_r;
    best_stamp_nxt = best_stamp_r;
    res_vld_nxt    = res_vld_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_way_nxt    = out_way_r;
    out_vv_nxt     = out_vv_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = {set_r, way_r};
    ram_wr_data    = use_cnt_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = {set_r, iss_way_r[WAY_W-1:0]};

    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt_r;
        ram_wr_data = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          set_nxt      = SET_W'(in_ch.set_index);
          way_nxt      = WAY_W'(in_ch.way_index);
          iss_way_nxt  = ITER_W'(rsv_r);
          cmp_vld_nxt  = 1'b0;
          first_nxt    = 1'b1;
          best_way_nxt = '0;
          res_vld_nxt  = 1'b0;
          state_nxt    = ST_DONE;
          case (in_ch.opcode)
            OP_VICTIM: begin
              if (set_ok && rsv_ok) begin
                state_nxt = ST_SCAN;
              end
            end
            OP_FILL: begin
              if (set_ok && way_ok) begin
                state_nxt = ST_WRITE;
              end
            end
            OP_ACCESS: begin
              if (set_ok && way_ok && in_ch.is_hit && !in_ch.is_write) begin
                state_nxt = ST_WRITE;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_WRITE: begin
        ram_wr_en   = 1'b1;
        use_cnt_nxt = use_cnt_r + 1'b1;
        state_nxt   = ST_DONE;
      end

      ST_SCAN: begin
        // issue one way per cycle; compare the way read in the previous cycle
        if (iss_way_r < WAYS_I) begin
          ram_rd_en   = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_way_nxt = iss_way_r[WAY_W-1:0];
          iss_way_nxt = iss_way_r + 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (cmp_vld_r) begin
          first_nxt = 1'b0;
          // strict less-than keeps the lower way on a tie
          if (first_r || (ram_rd_data < best_stamp_r)) begin
            best_way_nxt   = cmp_way_r;
            best_stamp_nxt = ram_rd_data;
          end
        end else if (iss_way_r >= WAYS_I) begin
          res_vld_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_way_nxt   = WAY_IDX_W'(best_way_r);
          out_vv_nxt    = res_vld_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.victim_way   = out_way_r;
  assign out_ch.victim_valid = out_vv_r;

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result beat presented during clearing pass");

  a_victim_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && state_nxt == ST_DONE) |->
      (32'(best_way_r) >= 32'(rsv_r) && 32'(best_way_r) < 32'(WAYS)))
    else $error("victim way outside eligible region");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> (use_cnt_r == STAMP_BITS'($past(use_cnt_r) + 1'b1)))
    else $error("use counter did not advance on stamp write");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_WRITE) |=> $stable(use_cnt_r))
    else $error("use counter moved without a stamp write");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (!ram_wr_en && !in_ch.ready))
    else $error("stamp write or accept during victim scan");

endmodule
